FILE: src/tcq_pkg.sv
package tcq_pkg;

    // Color mode codes
    localparam logic [2:0] MODE_TRUE    = 3'd0;
    localparam logic [2:0] MODE_IDX16   = 3'd1;
    localparam logic [2:0] MODE_IDX256  = 3'd2;
    localparam logic [2:0] MODE_RGB512  = 3'd3;
    localparam logic [2:0] MODE_RGB1024 = 3'd4;

    // Candidate chain: 16 base colors, one cube entry, 24 grays
    localparam int NUM_BASE  = 16;
    localparam int NUM_GRAY  = 24;
    localparam int NUM_CELLS = NUM_BASE + 1 + NUM_GRAY;
    localparam int CUBE_CELL = NUM_BASE;

    localparam int DIST_W = 18;  // 3 * 255^2 fits in 18 bits

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } rgb_t;

    // Word handed from cell to cell
    typedef struct packed {
        logic [2:0]        mode;
        rgb_t              pix;
        logic [DIST_W-1:0] best_d;
        logic [7:0]        best_i;
        rgb_t              best_rgb;
    } tcq_word_t;

    // Final result word
    typedef struct packed {
        logic       is_indexed;
        logic [7:0] pidx;
        rgb_t       rgb;
    } tcq_result_t;

    function automatic rgb_t base_rgb(input logic [3:0] idx);
        rgb_t c;
        case (idx)
            4'd0:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
            4'd1:    c = '{r: 8'd128, g: 8'd0,   b: 8'd0};
            4'd2:    c = '{r: 8'd0,   g: 8'd128, b: 8'd0};
            4'd3:    c = '{r: 8'd128, g: 8'd128, b: 8'd0};
            4'd4:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd128};
            4'd5:    c = '{r: 8'd128, g: 8'd0,   b: 8'd128};
            4'd6:    c = '{r: 8'd0,   g: 8'd128, b: 8'd128};
            4'd7:    c = '{r: 8'd192, g: 8'd192, b: 8'd192};
            4'd8:    c = '{r: 8'd128, g: 8'd128, b: 8'd128};
            4'd9:    c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
            4'd10:   c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
            4'd11:   c = '{r: 8'd255, g: 8'd255, b: 8'd0};
            4'd12:   c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
            4'd13:   c = '{r: 8'd255, g: 8'd0,   b: 8'd255};
            4'd14:   c = '{r: 8'd0,   g: 8'd255, b: 8'd255};
            default: c = '{r: 8'd255, g: 8'd255, b: 8'd255};
        endcase
        return c;
    endfunction

    // Nearest cube level; a tie goes to the lower level
    function automatic logic [2:0] cube_level(input logic [7:0] v);
        logic [2:0] l;
        if (v <= 8'd47)       l = 3'd0;
        else if (v <= 8'd115) l = 3'd1;
        else if (v <= 8'd155) l = 3'd2;
        else if (v <= 8'd195) l = 3'd3;
        else if (v <= 8'd235) l = 3'd4;
        else                  l = 3'd5;
        return l;
    endfunction

    function automatic logic [7:0] cube_value(input logic [2:0] l);
        logic [7:0] v;
        case (l)
            3'd0:    v = 8'd0;
            3'd1:    v = 8'd95;
            3'd2:    v = 8'd135;
            3'd3:    v = 8'd175;
            3'd4:    v = 8'd215;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] cube_code(input logic [2:0] r, input logic [2:0] g,
                                             input logic [2:0] b);
        return 8'd16 + 8'd36 * {5'd0, r} + 8'd6 * {5'd0, g} + {5'd0, b};
    endfunction

    // Round to 8 levels and rebuild; x / 255 as (x + (x >> 8) + 1) >> 8
    function automatic logic [7:0] quant8(input logic [7:0] v);
        logic [12:0] x;
        logic [12:0] q;
        logic [7:0]  o;
        x = 13'd7 * {5'd0, v} + 13'd127;
        q = (x + (x >> 8) + 13'd1) >> 8;
        case (q[2:0])
            3'd0:    o = 8'd0;
            3'd1:    o = 8'd36;
            3'd2:    o = 8'd73;
            3'd3:    o = 8'd109;
            3'd4:    o = 8'd146;
            3'd5:    o = 8'd182;
            3'd6:    o = 8'd219;
            default: o = 8'd255;
        endcase
        return o;
    endfunction

    // Round to 16 levels and rebuild; level * 17 is the nibble repeated
    function automatic logic [7:0] quant16(input logic [7:0] v);
        logic [12:0] x;
        logic [12:0] q;
        x = 13'd15 * {5'd0, v} + 13'd127;
        q = (x + (x >> 8) + 13'd1) >> 8;
        return {q[3:0], q[3:0]};
    endfunction

endpackage

FILE: src/tcq_cell.sv
module tcq_cell import tcq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  tcq_word_t  s_word,
    input  rgb_t       cand_rgb,
    input  logic [7:0] cand_idx,
    input  logic       cand_wide,   // candidate only counts in 256-color mode
    output logic       m_valid,
    input  logic       m_ready,
    output tcq_word_t  m_word
);

    logic              valid_reg, valid_next;
    tcq_word_t         word_reg, word_next;
    logic [7:0]        dr, dg, db;
    logic [15:0]       sr, sg, sb;
    logic [DIST_W-1:0] sq_dist;
    logic              use_cand;
    logic              load;

    // Squared distance to this cell's candidate
    always_comb begin
        dr = (s_word.pix.r > cand_rgb.r) ? s_word.pix.r - cand_rgb.r
                                         : cand_rgb.r - s_word.pix.r;
        dg = (s_word.pix.g > cand_rgb.g) ? s_word.pix.g - cand_rgb.g
                                         : cand_rgb.g - s_word.pix.g;
        db = (s_word.pix.b > cand_rgb.b) ? s_word.pix.b - cand_rgb.b
                                         : cand_rgb.b - s_word.pix.b;
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
        sq_dist = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
    end

    // Candidates arrive in rising index order, so a strict compare keeps the lower index
    always_comb begin
        use_cand = (s_word.mode == MODE_IDX256) ||
                   ((s_word.mode == MODE_IDX16) && !cand_wide);
        word_next = s_word;
        if (use_cand && (sq_dist < s_word.best_d)) begin
            word_next.best_d   = sq_dist;
            word_next.best_i   = cand_idx;
            word_next.best_rgb = cand_rgb;
        end
    end

    // Advance when this slot is empty or its word moves on
    assign s_ready    = !valid_reg || m_ready;
    assign load       = s_valid && s_ready;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= word_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_word  = word_reg;

endmodule

FILE: src/tcq_out.sv
module tcq_out import tcq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  tcq_word_t   s_word,
    output logic        m_valid,
    input  logic        m_ready,
    output tcq_result_t m_result
);

    logic        valid_reg, valid_next;
    tcq_result_t res_reg, res_next;
    logic        load;

    // Pick the result by mode: palette winner, quantized channels or the pixel itself
    always_comb begin
        res_next.is_indexed = 1'b0;
        res_next.pidx       = 8'd0;
        res_next.rgb        = s_word.pix;
        case (s_word.mode)
            MODE_IDX16, MODE_IDX256: begin
                res_next.is_indexed = 1'b1;
                res_next.pidx       = s_word.best_i;
                res_next.rgb        = s_word.best_rgb;
            end
            MODE_RGB512: begin
                res_next.rgb.r = quant8(s_word.pix.r);
                res_next.rgb.g = quant8(s_word.pix.g);
                res_next.rgb.b = quant8(s_word.pix.b);
            end
            MODE_RGB1024: begin
                res_next.rgb.r = quant8(s_word.pix.r);
                res_next.rgb.g = quant16(s_word.pix.g);
                res_next.rgb.b = quant8(s_word.pix.b);
            end
            default: begin
                res_next.rgb = s_word.pix;
            end
        endcase
    end

    // Hold the result until taken; take a new word when empty or draining
    assign s_ready    = !valid_reg || m_ready;
    assign load       = s_valid && s_ready;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = res_reg;

endmodule

FILE: src/terminal_color_quantizer.sv
// Channel   Direction  Payload
// s_axis    in         tdata: in_red, in_green, in_blue
// m_axis    out        tdata: palette_index, out_red, out_green, out_blue; tuser: is_indexed
// cfg       in         cfg_wdata: color_mode, written when cfg_we is high
//
// One pixel per cycle in and out while m_tready is high; the path runs through 41 compare cells (one per
// palette candidate) and the output register.
// The rate is set by the cell chain, where every cell holds one word and passes it on.
// Reset (aresetn low, synchronous) empties all cells and sets color_mode to true color.
// A stall on m_tready backs up cell by cell; empty cells keep taking words meanwhile.
module terminal_color_quantizer import tcq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // in_red[7:0], in_green[15:8], in_blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // palette_index[7:0], out_red[15:8],
                                    // out_green[23:16], out_blue[31:24]
    output logic        m_tuser,    // is_indexed[0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata
);

    logic [2:0]  mode_reg;
    logic        stage_valid [0:NUM_CELLS];
    logic        stage_ready [0:NUM_CELLS];
    tcq_word_t   stage_word  [0:NUM_CELLS];
    rgb_t        cube_rgb;
    logic [7:0]  cube_idx;
    logic [2:0]  lr, lg, lb;
    tcq_result_t result;

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_TRUE;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    // Build the word that enters the chain
    always_comb begin
        stage_word[0].mode     = mode_reg;
        stage_word[0].pix.r    = s_tdata[7:0];
        stage_word[0].pix.g    = s_tdata[15:8];
        stage_word[0].pix.b    = s_tdata[23:16];
        stage_word[0].best_d   = '1;
        stage_word[0].best_i   = 8'd0;
        stage_word[0].best_rgb = stage_word[0].pix;
    end
    assign stage_valid[0] = s_tvalid;
    assign s_tready       = stage_ready[0];

    // Cube candidate from the nearest level per channel
    always_comb begin
        lr         = cube_level(stage_word[CUBE_CELL].pix.r);
        lg         = cube_level(stage_word[CUBE_CELL].pix.g);
        lb         = cube_level(stage_word[CUBE_CELL].pix.b);
        cube_rgb.r = cube_value(lr);
        cube_rgb.g = cube_value(lg);
        cube_rgb.b = cube_value(lb);
        cube_idx   = cube_code(lr, lg, lb);
    end

    // Chain of compare cells in palette order
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        rgb_t       c_rgb;
        logic [7:0] c_idx;
        logic       c_wide;

        if (k < NUM_BASE) begin : g_base
            assign c_rgb  = base_rgb(4'(k));
            assign c_idx  = 8'(k);
            assign c_wide = 1'b0;
        end else if (k == CUBE_CELL) begin : g_cube
            assign c_rgb  = cube_rgb;
            assign c_idx  = cube_idx;
            assign c_wide = 1'b1;
        end else begin : g_gray
            localparam int GrayVal = 8 + 10 * (k - CUBE_CELL - 1);
            assign c_rgb  = '{r: 8'(GrayVal), g: 8'(GrayVal), b: 8'(GrayVal)};
            assign c_idx  = 8'(232 + k - CUBE_CELL - 1);
            assign c_wide = 1'b1;
        end

        tcq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .s_valid   (stage_valid[k]),
            .s_ready   (stage_ready[k]),
            .s_word    (stage_word[k]),
            .cand_rgb  (c_rgb),
            .cand_idx  (c_idx),
            .cand_wide (c_wide),
            .m_valid   (stage_valid[k+1]),
            .m_ready   (stage_ready[k+1]),
            .m_word    (stage_word[k+1])
        );
    end

    // Final select and output register
    tcq_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (stage_valid[NUM_CELLS]),
        .s_ready  (stage_ready[NUM_CELLS]),
        .s_word   (stage_word[NUM_CELLS]),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = {result.rgb.b, result.rgb.g, result.rgb.r, result.pidx};
    assign m_tuser = result.is_indexed;

    // A direct color word carries index zero
    a_direct_idx0 : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[7:0] == 8'd0))
        else $error("direct color word with nonzero palette index");

    // A gray index carries equal channels
    a_gray_eq : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser && (m_tdata[7:0] >= 8'd232)) |->
        ((m_tdata[15:8] == m_tdata[23:16]) && (m_tdata[23:16] == m_tdata[31:24])))
        else $error("gray index with unequal channels");

    // A base index carries its base color
    a_base_rgb : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser && (m_tdata[7:0] < 8'd16)) |->
        (m_tdata[31:8] == base_rgb(m_tdata[3:0])))
        else $error("base index with wrong color");

    // Input backs up only behind a waiting result
    a_stall_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with no result waiting");

endmodule

FILE: tb/sv/terminal_color_quantizer_tb.sv
`timescale 1ns / 100ps

module terminal_color_quantizer_tb;
    import tcq_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RANDOM_PIXELS = 1250;
    localparam int MAX_PRINTED   = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_wdata;

    // Mode as the block should hold it, and predicted words in arrival order
    logic [2:0]  cur_mode;
    tcq_result_t mapped_q[$];

    bit src_idle;
    bit snk_idle;
    int n_errors;
    int n_sent;
    int n_checked;
    int n_mode_writes;
    int cycle_count;

    terminal_color_quantizer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic rgb_t palette_color(input int idx);
        rgb_t c;
        logic [23:0] hex;
        int g;
        if (idx < 16) begin
            case (idx)
                0:       hex = 24'h000000;
                1:       hex = 24'h800000;
                2:       hex = 24'h008000;
                3:       hex = 24'h808000;
                4:       hex = 24'h000080;
                5:       hex = 24'h800080;
                6:       hex = 24'h008080;
                7:       hex = 24'hc0c0c0;
                8:       hex = 24'h808080;
                9:       hex = 24'hff0000;
                10:      hex = 24'h00ff00;
                11:      hex = 24'hffff00;
                12:      hex = 24'h0000ff;
                13:      hex = 24'hff00ff;
                14:      hex = 24'h00ffff;
                default: hex = 24'hffffff;
            endcase
            c.r = hex[23:16];
            c.g = hex[15:8];
            c.b = hex[7:0];
        end else if (idx < 232) begin
            c.r = 8'(step_value(((idx - 16) / 36) % 6));
            c.g = 8'(step_value(((idx - 16) / 6) % 6));
            c.b = 8'(step_value((idx - 16) % 6));
        end else begin
            g = 8 + 10 * (idx - 232);
            c.r = 8'(g);
            c.g = 8'(g);
            c.b = 8'(g);
        end
        return c;
    endfunction

    function automatic int step_value(input int s);
        int v;
        case (s)
            0:       v = 0;
            1:       v = 95;
            2:       v = 135;
            3:       v = 175;
            4:       v = 215;
            default: v = 255;
        endcase
        return v;
    endfunction

    function automatic int sq_distance(input rgb_t a, input rgb_t b);
        int dr, dg, db;
        dr = int'(a.r) - int'(b.r);
        dg = int'(a.g) - int'(b.g);
        db = int'(a.b) - int'(b.b);
        return dr * dr + dg * dg + db * db;
    endfunction

    // Closest cube step per channel; a tie keeps the lower step
    function automatic int nearest_step(input logic [7:0] v);
        int best, best_d, d, s;
        best = 0;
        best_d = 1 << 30;
        for (s = 0; s < 6; s++) begin
            d = (int'(v) - step_value(s)) * (int'(v) - step_value(s));
            if (d < best_d) begin
                best_d = d;
                best = s;
            end
        end
        return best;
    endfunction

    function automatic logic [7:0] requantize(input logic [7:0] v, input int levels);
        int lvl;
        lvl = (int'(v) * (levels - 1) + 127) / 255;
        return 8'((lvl * 255 + (levels - 1) / 2) / (levels - 1));
    endfunction

    function automatic tcq_result_t map_pixel(input logic [2:0] mode, input rgb_t px);
        tcq_result_t res;
        int cands[$];
        int best_d, best_i, d, k;
        res.is_indexed = 1'b0;
        res.pidx = 8'd0;
        res.rgb = px;
        if (mode == MODE_IDX16 || mode == MODE_IDX256) begin
            for (k = 0; k < 16; k++) cands.push_back(k);
            if (mode == MODE_IDX256) begin
                cands.push_back(16 + 36 * nearest_step(px.r) + 6 * nearest_step(px.g)
                                + nearest_step(px.b));
                for (k = 232; k < 256; k++) cands.push_back(k);
            end
            best_d = 1 << 30;
            best_i = 0;
            foreach (cands[j]) begin
                d = sq_distance(px, palette_color(cands[j]));
                if (d < best_d || (d == best_d && cands[j] < best_i)) begin
                    best_d = d;
                    best_i = cands[j];
                end
            end
            res.is_indexed = 1'b1;
            res.pidx = 8'(best_i);
            res.rgb = palette_color(best_i);
        end else if (mode == MODE_RGB512 || mode == MODE_RGB1024) begin
            res.rgb.r = requantize(px.r, 8);
            res.rgb.g = requantize(px.g, (mode == MODE_RGB1024) ? 16 : 8);
            res.rgb.b = requantize(px.b, 8);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- driving

    function automatic rgb_t make_rgb(input int r, input int g, input int b);
        rgb_t c;
        c.r = 8'(r);
        c.g = 8'(g);
        c.b = 8'(b);
        return c;
    endfunction

    // Send one pixel; returns right after the edge that takes the word
    task automatic send_pixel(input rgb_t px);
        int gap;
        gap = src_idle ? $urandom_range(0, 15) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = px;
        do @(posedge aclk); while (!s_tready);
        mapped_q.push_back(map_pixel(cur_mode, px));
        n_sent++;
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic drain_pixels();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (mapped_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_mode(input logic [2:0] mode);
        drain_pixels();
        repeat (2) @(negedge aclk);
        cfg_we = 1'b1;
        cfg_wdata = mode;
        @(negedge aclk);
        cfg_we = 1'b0;
        cur_mode = mode;
        n_mode_writes++;
    endtask

    task automatic report_mismatch(input string what);
        if (n_errors < MAX_PRINTED) $display("MISMATCH @%0d: %s", cycle_count, what);
        n_errors++;
    endtask

    task automatic check_result();
        tcq_result_t got, want;
        got.is_indexed = m_tuser;
        got.pidx = m_tdata[7:0];
        got.rgb = m_tdata[31:8];
        if (mapped_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h/%b", m_tdata, m_tuser));
        end else begin
            want = mapped_q.pop_front();
            n_checked++;
            if (got.is_indexed !== want.is_indexed)
                report_mismatch($sformatf("is_indexed %b, want %b",
                                          got.is_indexed, want.is_indexed));
            if (got.pidx !== want.pidx)
                report_mismatch($sformatf("palette_index %0d, want %0d", got.pidx, want.pidx));
            if (got.rgb.r !== want.rgb.r)
                report_mismatch($sformatf("out_red %0d, want %0d", got.rgb.r, want.rgb.r));
            if (got.rgb.g !== want.rgb.g)
                report_mismatch($sformatf("out_green %0d, want %0d", got.rgb.g, want.rgb.g));
            if (got.rgb.b !== want.rgb.b)
                report_mismatch($sformatf("out_blue %0d, want %0d", got.rgb.b, want.rgb.b));
        end
    endtask

    // Result side: stall a random number of cycles per word, then take and check it
    initial begin
        int stall;
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(negedge aclk);
        forever begin
            stall = snk_idle ? $urandom_range(0, 15) : 0;
            repeat (stall) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
            @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_result();
        end
    end

    // ---------------------------------------------------------------- tests

    // True color and the unused mode codes pass the pixel straight through
    task automatic test_passthrough();
        set_mode(MODE_TRUE);
        send_pixel(make_rgb(0, 0, 0));
        send_pixel(make_rgb(255, 255, 255));
        for (int m = 5; m < 8; m++) begin
            set_mode(3'(m));
            send_pixel(make_rgb(200, 100, 50));
        end
    endtask

    // An exact base color, a pixel equally far from black and dark red, and an off-palette pixel
    task automatic test_indexed16();
        set_mode(MODE_IDX16);
        send_pixel(make_rgb(64, 0, 0));
        send_pixel(make_rgb(192, 192, 192));
        send_pixel(make_rgb(160, 96, 32));
    endtask

    // Cube step tie, gray tie, an exact cube color and channels on step boundaries
    task automatic test_indexed256();
        set_mode(MODE_IDX256);
        send_pixel(make_rgb(115, 115, 115));
        send_pixel(make_rgb(13, 13, 13));
        send_pixel(make_rgb(95, 135, 175));
        send_pixel(make_rgb(48, 47, 236));
    endtask

    // Rounding boundaries of the 8-step and 16-step channels
    task automatic test_requantize();
        set_mode(MODE_RGB512);
        send_pixel(make_rgb(18, 19, 255));
        send_pixel(make_rgb(0, 128, 127));
        set_mode(MODE_RGB1024);
        send_pixel(make_rgb(8, 9, 136));
        send_pixel(make_rgb(255, 0, 119));
    endtask

    function automatic int near_value(input int center);
        int v;
        v = center + $urandom_range(0, 6) - 3;
        return (v < 0) ? 0 : (v > 255) ? 255 : v;
    endfunction

    function automatic rgb_t random_pixel();
        int kind, g;
        kind = $urandom_range(0, 3);
        case (kind)
            0: return make_rgb($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255));
            1: begin
                // Near the gray ramp, where gray, cube and base colors compete
                g = $urandom_range(0, 255);
                return make_rgb(near_value(g), near_value(g), near_value(g));
            end
            2: return make_rgb(($urandom_range(0, 1) != 0) ? 255 : 0,
                               $urandom_range(0, 255),
                               ($urandom_range(0, 1) != 0) ? 255 : 0);
            default: return make_rgb(near_value(step_value($urandom_range(0, 5))),
                                     near_value(128 * $urandom_range(0, 2)),
                                     near_value(step_value($urandom_range(0, 5))));
        endcase
    endfunction

    // Phases of random pixels, each under a random mode and idling pattern
    task automatic test_random_pixels();
        int sent, run;
        logic [2:0] mode;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            if ($urandom_range(0, 7) == 0) mode = 3'($urandom_range(5, 7));
            else mode = 3'($urandom_range(0, 4));
            set_mode(mode);
            src_idle = ($urandom_range(0, 2) != 0);
            snk_idle = ($urandom_range(0, 2) != 0);
            run = $urandom_range(20, 80);
            repeat (run) begin
                send_pixel(random_pixel());
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_wdata = MODE_TRUE;
        cur_mode = MODE_TRUE;
        src_idle = 1'b1;
        snk_idle = 1'b1;
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_mode_writes = 0;
        cycle_count = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_passthrough();
        test_indexed16();
        test_indexed256();
        test_requantize();
        test_random_pixels();

        // Let the pipeline empty, then allow for stray words
        drain_pixels();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mapped_q.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", mapped_q.size()));

        $display("Sent %0d pixels under %0d mode writes covering all eight mode codes,",
                 n_sent, n_mode_writes);
        $display("checked %0d mapped words with random gaps and stalls on both sides",
                 n_checked);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
